@@ src/wt1u_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and character helpers for the WSPR Type 1 unpacker.
package wt1u_pkg;

    // Field widths of the message.
    localparam int unsigned MSG_BITS  = 50;
    localparam int unsigned CALL_BITS = 28;
    localparam int unsigned GRID_BITS = 22;

    // Claimed length that a well-formed word carries.
    localparam logic [5:0] PAYLOAD_COUNT = 6'(MSG_BITS);

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_LOC = 2'd2;

    // ASCII characters used by the formatters.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;

    // Reciprocal constants for exact division of the 28-bit callsign number.
    // Each multiplier is ceil(2^k / D) with 2^(k-28) >= D, so the top bits of
    // the product are the exact quotient for every 28-bit dividend.
    localparam int unsigned RECIP_W = 29;
    localparam int unsigned PROD_W  = CALL_BITS + RECIP_W;

    localparam int unsigned SH_27      = 33;
    localparam int unsigned SH_729     = 38;
    localparam int unsigned SH_19683   = 43;
    localparam int unsigned SH_196830  = 46;
    localparam int unsigned SH_7085880 = 51;

    localparam int unsigned Q27_W      = 24;
    localparam int unsigned Q729_W     = 19;
    localparam int unsigned Q19683_W   = 14;
    localparam int unsigned Q196830_W  = 11;
    localparam int unsigned Q7085880_W = 6;

    localparam logic [RECIP_W-1:0] RECIP_27 =
        RECIP_W'(((64'd1 << SH_27) + 64'd26) / 64'd27);
    localparam logic [RECIP_W-1:0] RECIP_729 =
        RECIP_W'(((64'd1 << SH_729) + 64'd728) / 64'd729);
    localparam logic [RECIP_W-1:0] RECIP_19683 =
        RECIP_W'(((64'd1 << SH_19683) + 64'd19682) / 64'd19683);
    localparam logic [RECIP_W-1:0] RECIP_196830 =
        RECIP_W'(((64'd1 << SH_196830) + 64'd196829) / 64'd196830);
    localparam logic [RECIP_W-1:0] RECIP_7085880 =
        RECIP_W'(((64'd1 << SH_7085880) + 64'd7085879) / 64'd7085880);

    // Locator field and its division by 180.
    localparam int unsigned LOC_BITS   = 15;
    localparam int unsigned LQ_BITS    = 8;
    localparam int unsigned RECIP180_W = 16;
    localparam int unsigned SH_180     = 23;
    localparam logic [RECIP180_W-1:0] RECIP_180 =
        RECIP180_W'(((64'd1 << SH_180) + 64'd179) / 64'd180);
    localparam logic [LOC_BITS-1:0]  LOC_LIMIT    = 15'd32400;
    localparam logic [GRID_BITS-1:0] POWER_OFFSET = 22'd64;

    // Input word.
    typedef struct packed {
        logic [MSG_BITS-1:0] payload;
        logic [5:0]          bit_count;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [47:0] callsign_text;
        logic [2:0]  callsign_length;
        logic [31:0] locator_text;
        logic [6:0]  power_level;
        logic [1:0]  status;
    } t_out_word;

    // Word held between the divider rank and the formatting rank.
    typedef struct packed {
        logic [CALL_BITS-1:0]  n;
        logic [Q27_W-1:0]      q27;
        logic [Q729_W-1:0]     q729;
        logic [Q19683_W-1:0]   q19683;
        logic [Q196830_W-1:0]  q196830;
        logic [Q7085880_W-1:0] q7085880;
        logic [LOC_BITS-1:0]   loc;
        logic [LQ_BITS-1:0]    lq;
        logic [6:0]            pwr;
        logic                  loc_bad;
        logic                  len_bad;
    } t_mid_word;

    // Base-37 digit: 0-9, then A-Z, anything else is a space.
    function automatic logic [7:0] base37_char(input logic [5:0] v);
        logic [7:0] c;
        if (v <= 6'd9) begin
            c = CHAR_ZERO + {2'b00, v};
        end else if (v <= 6'd35) begin
            c = CHAR_A + ({2'b00, v} - 8'd10);
        end else begin
            c = CHAR_SPACE;
        end
        return c;
    endfunction

    // Suffix digit: 0-25 are A-Z, 26 and above a space.
    function automatic logic [7:0] suffix_char(input logic [4:0] v);
        logic [7:0] c;
        if (v <= 5'd25) begin
            c = CHAR_A + {3'b000, v};
        end else begin
            c = CHAR_SPACE;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ src/wspr_type1_unpack.sv @@
// WSPR Type 1 message unpacker, top level.
//
// One input word carries a 50-bit Type 1 payload and its claimed bit count;
// one result word per input gives the trimmed callsign and its length, the
// four-character locator, the power field and a status code.
// Both channels use valid and stall: a word moves at a rising edge where
// valid is high and stall is low.
// The block takes one word per cycle and keeps that rate as long as the
// receiver does not stall. A result reaches the output through three register
// ranks: the input register, the rank of reciprocal multipliers that divides
// the callsign number and the locator field, and the result register that
// holds the formatted text.
// When the receiver stalls, the result word holds and the words behind it
// close up into empty ranks; o_in_stall rises only when all three ranks are
// full and the result is stalled.
// Synchronous reset empties all three ranks; no word is lost or created.
`timescale 1ns / 1ps
`default_nettype none
module wspr_type1_unpack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  wt1u_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output wt1u_pkg::t_out_word  o_out_word
);

    wt1u_pkg::t_in_word  r_s1;
    wt1u_pkg::t_mid_word r_s2;
    wt1u_pkg::t_out_word r_out;
    wt1u_pkg::t_mid_word n_s2;
    wt1u_pkg::t_out_word n_out;
    logic                r_s1_valid, r_s2_valid, r_out_valid;
    logic                s1_ready, s2_ready, out_ready;

    logic [wt1u_pkg::CALL_BITS-1:0]   s1_n;
    logic [wt1u_pkg::GRID_BITS-1:0]   s1_m, s1_m_off;
    logic [wt1u_pkg::LOC_BITS-1:0]    s1_loc;
    logic [wt1u_pkg::PROD_W-1:0]      p27, p729, p19683, p196830, p7085880;
    logic [wt1u_pkg::LOC_BITS + wt1u_pkg::RECIP180_W - 1:0] p180;

    logic [47:0] call_text;
    logic [2:0]  call_length;
    logic [31:0] loc_text;

    // Each rank loads when it is empty or its word moves on.
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s2_ready   = !r_s2_valid || out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_stall = !s1_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Split the payload into the callsign number and the grid/power field.
    assign s1_n     = r_s1.payload[wt1u_pkg::MSG_BITS-1 -: wt1u_pkg::CALL_BITS];
    assign s1_m     = r_s1.payload[wt1u_pkg::GRID_BITS-1:0];
    assign s1_m_off = s1_m - wt1u_pkg::POWER_OFFSET;
    assign s1_loc   = s1_m_off[wt1u_pkg::GRID_BITS-1:7];

    // Exact quotients of the callsign number by the products of its radices.
    assign p27      = {{wt1u_pkg::RECIP_W{1'b0}}, s1_n}
                    * {{wt1u_pkg::CALL_BITS{1'b0}}, wt1u_pkg::RECIP_27};
    assign p729     = {{wt1u_pkg::RECIP_W{1'b0}}, s1_n}
                    * {{wt1u_pkg::CALL_BITS{1'b0}}, wt1u_pkg::RECIP_729};
    assign p19683   = {{wt1u_pkg::RECIP_W{1'b0}}, s1_n}
                    * {{wt1u_pkg::CALL_BITS{1'b0}}, wt1u_pkg::RECIP_19683};
    assign p196830  = {{wt1u_pkg::RECIP_W{1'b0}}, s1_n}
                    * {{wt1u_pkg::CALL_BITS{1'b0}}, wt1u_pkg::RECIP_196830};
    assign p7085880 = {{wt1u_pkg::RECIP_W{1'b0}}, s1_n}
                    * {{wt1u_pkg::CALL_BITS{1'b0}}, wt1u_pkg::RECIP_7085880};

    // Exact quotient of the locator field by 180.
    assign p180 = {{wt1u_pkg::RECIP180_W{1'b0}}, s1_loc}
                * {{wt1u_pkg::LOC_BITS{1'b0}}, wt1u_pkg::RECIP_180};

    // Next contents of the divider rank.
    always_comb begin
        n_s2.n        = s1_n;
        n_s2.q27      = p27[wt1u_pkg::SH_27 +: wt1u_pkg::Q27_W];
        n_s2.q729     = p729[wt1u_pkg::SH_729 +: wt1u_pkg::Q729_W];
        n_s2.q19683   = p19683[wt1u_pkg::SH_19683 +: wt1u_pkg::Q19683_W];
        n_s2.q196830  = p196830[wt1u_pkg::SH_196830 +: wt1u_pkg::Q196830_W];
        n_s2.q7085880 = p7085880[wt1u_pkg::SH_7085880 +: wt1u_pkg::Q7085880_W];
        n_s2.loc      = s1_loc;
        n_s2.lq       = p180[wt1u_pkg::SH_180 +: wt1u_pkg::LQ_BITS];
        n_s2.pwr      = s1_m_off[6:0];
        // A field below the offset wraps to a huge locator, so it is out of range.
        n_s2.loc_bad  = (s1_m < wt1u_pkg::POWER_OFFSET) || (s1_loc >= wt1u_pkg::LOC_LIMIT);
        n_s2.len_bad  = (r_s1.bit_count != wt1u_pkg::PAYLOAD_COUNT);
    end

    // Callsign and locator formatting.
    wt1u_call_fmt u_call_fmt (
        .i_n        (r_s2.n),
        .i_q27      (r_s2.q27),
        .i_q729     (r_s2.q729),
        .i_q19683   (r_s2.q19683),
        .i_q196830  (r_s2.q196830),
        .i_q7085880 (r_s2.q7085880),
        .o_text     (call_text),
        .o_length   (call_length)
    );

    wt1u_loc_fmt u_loc_fmt (
        .i_loc  (r_s2.loc),
        .i_lq   (r_s2.lq),
        .o_text (loc_text)
    );

    // Assemble the result word; a wrong bit count clears every field but the status.
    always_comb begin
        n_out = '0;
        priority if (r_s2.len_bad) begin
            n_out.status = wt1u_pkg::ST_BAD_LEN;
        end else if (r_s2.loc_bad) begin
            n_out.callsign_text   = call_text;
            n_out.callsign_length = call_length;
            n_out.power_level     = r_s2.pwr;
            n_out.status          = wt1u_pkg::ST_BAD_LOC;
        end else begin
            n_out.callsign_text   = call_text;
            n_out.callsign_length = call_length;
            n_out.locator_text    = loc_text;
            n_out.power_level     = r_s2.pwr;
            n_out.status          = wt1u_pkg::ST_OK;
        end
    end

    // Occupancy of the three ranks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // Payload of the three ranks.
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1 <= i_in_word;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2 <= n_s2;
        end
        if (out_ready && r_s2_valid) begin
            r_out <= n_out;
        end
    end

    // The input side stalls only when every rank is full and the result is held.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s2_valid && r_out_valid && i_out_stall))
        else $error("input stalled while a rank was free");

    // A word in the divider rank that cannot move stays there.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s2_ready) |=> r_s2_valid)
        else $error("word lost from the divider rank");

    // Any error status comes with a cleared locator.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != wt1u_pkg::ST_OK))
        |-> (o_out_word.locator_text == 32'd0))
        else $error("locator text given with an error status");

    // A wrong bit count clears the callsign and power as well.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == wt1u_pkg::ST_BAD_LEN))
        |-> ((o_out_word.callsign_text == 48'd0) && (o_out_word.callsign_length == 3'd0)
             && (o_out_word.power_level == 7'd0)))
        else $error("fields not cleared on a wrong bit count");

endmodule
`default_nettype wire

@@ src/wt1u_call_fmt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Callsign formatter: digits from the exact quotients, character mapping and trimming.
module wt1u_call_fmt (
    input  logic [wt1u_pkg::CALL_BITS-1:0]  i_n,
    input  logic [wt1u_pkg::Q27_W-1:0]      i_q27,
    input  logic [wt1u_pkg::Q729_W-1:0]     i_q729,
    input  logic [wt1u_pkg::Q19683_W-1:0]   i_q19683,
    input  logic [wt1u_pkg::Q196830_W-1:0]  i_q196830,
    input  logic [wt1u_pkg::Q7085880_W-1:0] i_q7085880,
    output logic [47:0]                     o_text,
    output logic [2:0]                      o_length
);

    logic [27:0] t5, diff5;
    logic [23:0] t4, diff4;
    logic [18:0] t3, diff3;
    logic [13:0] t2, diff2;
    logic [10:0] t1, diff1;
    logic [4:0]  d5, d4, d3;
    logic [3:0]  d2;
    logic [5:0]  d1, d0;
    logic [7:0]  raw [0:7];
    logic [5:0]  is_space;
    logic [2:0]  first_pos;
    logic [2:0]  last_pos;

    // Each digit is a quotient less the radix times the next quotient.
    assign t5    = {4'b0, i_q27} * 28'd27;
    assign diff5 = i_n - t5;
    assign d5    = diff5[4:0];

    assign t4    = {5'b0, i_q729} * 24'd27;
    assign diff4 = i_q27 - t4;
    assign d4    = diff4[4:0];

    assign t3    = {5'b0, i_q19683} * 19'd27;
    assign diff3 = i_q729 - t3;
    assign d3    = diff3[4:0];

    assign t2    = {3'b0, i_q196830} * 14'd10;
    assign diff2 = i_q19683 - t2;
    assign d2    = diff2[3:0];

    assign t1    = {5'b0, i_q7085880} * 11'd36;
    assign diff1 = i_q196830 - t1;
    assign d1    = diff1[5:0];

    assign d0    = i_q7085880;

    // Character mapping; the two spare slots read as spaces.
    assign raw[0] = wt1u_pkg::base37_char(d0);
    assign raw[1] = wt1u_pkg::base37_char(d1);
    assign raw[2] = wt1u_pkg::base37_char({2'b00, d2});
    assign raw[3] = wt1u_pkg::suffix_char(d3);
    assign raw[4] = wt1u_pkg::suffix_char(d4);
    assign raw[5] = wt1u_pkg::suffix_char(d5);
    assign raw[6] = wt1u_pkg::CHAR_SPACE;
    assign raw[7] = wt1u_pkg::CHAR_SPACE;

    // Find the first and last characters that are not spaces.
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            is_space[i] = (raw[i] == wt1u_pkg::CHAR_SPACE);
        end
        first_pos = 3'd6;
        for (int i = 5; i >= 0; i--) begin
            if (!is_space[i]) begin
                first_pos = 3'(i);
            end
        end
        last_pos = 3'd0;
        for (int i = 0; i < 6; i++) begin
            if (!is_space[i]) begin
                last_pos = 3'(i);
            end
        end
        if (&is_space) begin
            o_length = 3'd0;
        end else begin
            o_length = last_pos - first_pos + 3'd1;
        end
    end

    // Left-align the kept characters and pad on the right with spaces.
    always_comb begin
        logic [3:0] pos;
        for (int i = 0; i < 6; i++) begin
            pos = {1'b0, first_pos} + 4'(i);
            if (3'(i) < o_length) begin
                o_text[47 - 8 * i -: 8] = raw[pos[2:0]];
            end else begin
                o_text[47 - 8 * i -: 8] = wt1u_pkg::CHAR_SPACE;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/wt1u_loc_fmt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Locator formatter: turns the locator field and its quotient by 180 into four ASCII characters.
module wt1u_loc_fmt (
    input  logic [wt1u_pkg::LOC_BITS-1:0] i_loc,
    input  logic [wt1u_pkg::LQ_BITS-1:0]  i_lq,
    output logic [31:0]                   o_text
);

    logic [7:0]  d0, d1;
    logic [14:0] lq_back, d1_full;
    logic [15:0] p0, p1;
    logic [4:0]  d0_hi, d1_hi;
    logic [7:0]  d0_rem, d1_rem;

    // Longitude index counts down from the top, latitude index is the remainder.
    assign d0      = 8'd179 - i_lq;
    assign lq_back = {7'b0, i_lq} * 15'd180;
    assign d1_full = i_loc - lq_back;
    assign d1      = d1_full[7:0];

    // Split each index into tens and units; 205/2048 is exact below 1029.
    assign p0     = {8'b0, d0} * 16'd205;
    assign p1     = {8'b0, d1} * 16'd205;
    assign d0_hi  = p0[15:11];
    assign d1_hi  = p1[15:11];
    assign d0_rem = d0 - ({3'b0, d0_hi} * 8'd10);
    assign d1_rem = d1 - ({3'b0, d1_hi} * 8'd10);

    assign o_text = {wt1u_pkg::CHAR_A + {3'b0, d0_hi},
                     wt1u_pkg::CHAR_A + {3'b0, d1_hi},
                     wt1u_pkg::CHAR_ZERO + {4'b0, d0_rem[3:0]},
                     wt1u_pkg::CHAR_ZERO + {4'b0, d1_rem[3:0]}};

endmodule
`default_nettype wire
